### rtl/vfc_pkg.sv
package vfc_pkg;

  // plane coefficient and offset width
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned REG_COUNT = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PLANE_W   = 4 * COEF_W;

  // test kinds
  localparam logic [1:0] ACT_POINT  = 2'd0;
  localparam logic [1:0] ACT_SPHERE = 2'd1;
  localparam logic [1:0] ACT_BOX    = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_OUT   = 2'd0;
  localparam logic [1:0] VERDICT_IN    = 2'd1;
  localparam logic [1:0] VERDICT_CROSS = 2'd2;

  // per-plane outcome flags
  typedef struct packed {
    logic pt_out;
    logic sph_out;
    logic box_cull;
    logic box_cross;
  } plane_flags_t;

endpackage

### rtl/view_frustum_cull_test.sv
// Frustum cull test: one point, sphere or box test per clock, no stalls.
// A request is taken at every edge with start_i high (busy_o stays low);
// its verdict appears on verdict_o with done_o high for one cycle, in
// request order. The four register stages are: the coefficient
// products, the per-plane distance sums (center, box minimum and box
// maximum), the per-plane compares, and the verdict reduction.
// Planes are written through the cfg channel, which is always ready, and
// must only change while no request is in flight.
module view_frustum_cull_test #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_FRAC   = 14,
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] far_x_i,
  input  logic signed [COORD_WIDTH-1:0] far_y_i,
  input  logic signed [COORD_WIDTH-1:0] far_z_i,
  input  logic [COORD_WIDTH-2:0]        radius_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vfc_pkg::PLANE_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [1:0]                    verdict_o
);

  localparam int unsigned NP = (PLANE_COUNT < vfc_pkg::REG_COUNT) ?
                               PLANE_COUNT : vfc_pkg::REG_COUNT;
  localparam int unsigned PW = COORD_WIDTH + vfc_pkg::COEF_W;
  localparam int unsigned DW = vfc_pkg::COEF_W + COEF_FRAC;
  localparam int unsigned SW = ((PW > DW) ? PW : DW) + 3;

  // plane registers
  logic [vfc_pkg::PLANE_W-1:0] plane_q [vfc_pkg::REG_COUNT];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vfc_pkg::REG_COUNT; i++) plane_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int i = 0; i < vfc_pkg::REG_COUNT; i++) begin
        if (cfg_index_i == vfc_pkg::CFG_IDX_W'(i)) plane_q[i] <= cfg_data_i;
      end
    end
  end

  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: products, index 0/1 x (pos/far), 2/3 y, 4/5 z
  logic signed [PW-1:0] prod_d [NP][6];
  logic signed [PW-1:0] prod_q [NP][6];
  logic                 v1_q;
  logic [1:0]           act1_q;
  logic [COORD_WIDTH-2:0] rad1_q;

  always_comb begin
    logic signed [vfc_pkg::COEF_W-1:0] ca, cb, cc;
    for (int p = 0; p < NP; p++) begin
      ca = plane_q[p][15:0];
      cb = plane_q[p][31:16];
      cc = plane_q[p][47:32];
      prod_d[p][0] = PW'(ca * pos_x_i);
      prod_d[p][1] = PW'(ca * far_x_i);
      prod_d[p][2] = PW'(cb * pos_y_i);
      prod_d[p][3] = PW'(cb * far_y_i);
      prod_d[p][4] = PW'(cc * pos_z_i);
      prod_d[p][5] = PW'(cc * far_z_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    act1_q <= action_i;
    rad1_q <= radius_i;
  end

  // stage 2: center distance, box min and max distances
  logic signed [SW-1:0] dpos_d [NP], dmin_d [NP], dmax_d [NP];
  logic signed [SW-1:0] dpos_q [NP], dmin_q [NP], dmax_q [NP];
  logic signed [SW-1:0] lim_d, lim_q;
  logic                 v2_q;
  logic [1:0]           act2_q;

  always_comb begin
    logic signed [SW-1:0] dofs, lo, hi, e0, e1;
    for (int p = 0; p < NP; p++) begin
      dofs = SW'($signed(plane_q[p][63:48])) <<< COEF_FRAC;
      dpos_d[p] = SW'(prod_q[p][0]) + SW'(prod_q[p][2]) + SW'(prod_q[p][4]) + dofs;
      lo = dofs;
      hi = dofs;
      for (int a = 0; a < 3; a++) begin
        e0 = SW'(prod_q[p][2*a]);
        e1 = SW'(prod_q[p][2*a+1]);
        lo = lo + ((e0 < e1) ? e0 : e1);
        hi = hi + ((e0 < e1) ? e1 : e0);
      end
      dmin_d[p] = lo;
      dmax_d[p] = hi;
    end
    lim_d = -($signed(SW'(rad1_q)) <<< COEF_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    dpos_q <= dpos_d;
    dmin_q <= dmin_d;
    dmax_q <= dmax_d;
    lim_q  <= lim_d;
    act2_q <= act1_q;
  end

  // stage 3: per-plane compares
  vfc_pkg::plane_flags_t flg_d [NP], flg_q [NP];
  logic       v3_q;
  logic [1:0] act3_q;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      flg_d[p].pt_out    = (dpos_q[p] <= 0);
      flg_d[p].sph_out   = (dpos_q[p] <= lim_q);
      flg_d[p].box_cull  = (dmax_q[p] < 0);
      flg_d[p].box_cross = (dmin_q[p] < 0) && !(dmax_q[p] < 0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    flg_q  <= flg_d;
    act3_q <= act2_q;
  end

  // stage 4: reduce over planes into the verdict
  logic [1:0] verdict_d, verdict_q;
  logic       done_q;

  always_comb begin
    logic any_pt, any_sph, any_cull, any_cross;
    any_pt    = 1'b0;
    any_sph   = 1'b0;
    any_cull  = 1'b0;
    any_cross = 1'b0;
    for (int p = 0; p < NP; p++) begin
      any_pt    = any_pt    | flg_q[p].pt_out;
      any_sph   = any_sph   | flg_q[p].sph_out;
      any_cull  = any_cull  | flg_q[p].box_cull;
      any_cross = any_cross | flg_q[p].box_cross;
    end
    case (act3_q)
      vfc_pkg::ACT_POINT:
        verdict_d = any_pt ? vfc_pkg::VERDICT_OUT : vfc_pkg::VERDICT_IN;
      vfc_pkg::ACT_SPHERE:
        verdict_d = any_sph ? vfc_pkg::VERDICT_OUT : vfc_pkg::VERDICT_IN;
      vfc_pkg::ACT_BOX: begin
        if (any_cull)       verdict_d = vfc_pkg::VERDICT_OUT;
        else if (any_cross) verdict_d = vfc_pkg::VERDICT_CROSS;
        else                verdict_d = vfc_pkg::VERDICT_IN;
      end
      default: verdict_d = vfc_pkg::VERDICT_OUT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign done_o    = done_q;
  assign verdict_o = verdict_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |=> done_o) else $error("result strobe lost in final stage");

  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q ##1 v2_q ##1 v3_q) else $error("valid bit dropped in pipeline");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (verdict_o != 2'd3)) else $error("illegal verdict code");

  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && verdict_o == vfc_pkg::VERDICT_CROSS) |-> $past(act3_q) == vfc_pkg::ACT_BOX)
    else $error("intersecting verdict for a non-box test");

endmodule
